FILE: rtl/core/isms_pkg.sv
package isms_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_DUPLICATE = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: rtl/core/integer_set_membership_table.sv
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------
// in       | in_valid, in_ready  | op, value
// out      | out_valid, out_ready| was_present, status, member_count
//
// each request runs the parallel compare in all cells, then the
// shift/append through the cell row and the result write.
// in_ready is high whenever no request is in progress; a finished result
// sits in the output register while the next request is compared.
// a request waits in its apply state while the output register is full.
// reset empties the set; cell values are not cleared.
module integer_set_membership_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          op,
  input  logic signed [isms_pkg::VAL_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                was_present,
  output logic [1:0]                          status,
  output logic [isms_pkg::CNT_OUT_W-1:0]      member_count
);
  import isms_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic             state;
  logic [1:0]       op_q;
  logic [VAL_W-1:0] key_q;
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] held_count_next;

  logic [CAPACITY-1:0]  valid_vec;
  logic [CAPACITY-1:0]  match_vec;
  logic [CAPACITY:0]    hit_chain;
  logic [VAL_W-1:0]     value_vec [CAPACITY];
  logic [VAL_W-1:0]     key_bus;

  cell_ctl_t ctl;
  logic      accept;
  logic      apply;
  logic      present;
  logic      full;
  logic [1:0] stat;
  logic [CNT_W+CNT_OUT_W-1:0] count_wide;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign apply    = (state == ST_APPLY) && (!out_valid || out_ready);
  assign present  = |match_vec;
  assign full     = (held_count >= CNT_W'(CAPACITY));
  assign key_bus  = (state == ST_IDLE) ? value : key_q;

  always_comb begin
    ctl         = '0;
    ctl.capture = accept;
    stat        = STAT_DONE;
    held_count_next = held_count;
    if (apply) begin
      case (op_q)
        OP_INSERT: begin
          if (present) begin
            stat = STAT_DUPLICATE;
          end else if (full) begin
            stat = STAT_FULL;
          end else begin
            ctl.insert      = 1'b1;
            held_count_next = held_count + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (!present) begin
            stat = STAT_NOT_FOUND;
          end else begin
            ctl.remove      = 1'b1;
            held_count_next = held_count - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          ctl.clear       = 1'b1;
          held_count_next = '0;
        end
        default: begin
          stat = STAT_DONE;
        end
      endcase
    end
  end

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             lv;
    logic [VAL_W-1:0] rv;
    logic             rvld;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_mid
      assign lv = valid_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv   = key_q;
      assign rvld = 1'b0;
    end else begin : g_inner
      assign rv   = value_vec[i+1];
      assign rvld = valid_vec[i+1];
    end
    isms_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (key_bus),
      .left_valid  (lv),
      .left_hit    (hit_chain[i]),
      .right_value (rv),
      .right_valid (rvld),
      .value       (value_vec[i]),
      .valid       (valid_vec[i]),
      .match       (match_vec[i]),
      .hit_out     (hit_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (accept) begin
        state <= ST_APPLY;
      end else if (apply) begin
        state <= ST_IDLE;
      end
      if (apply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign count_wide = {{CNT_OUT_W{1'b0}}, held_count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op;
      key_q <= value;
    end
    if (apply) begin
      was_present  <= present && (op_q != OP_CLEAR);
      status       <= stat;
      member_count <= count_wide[CNT_OUT_W-1:0];
    end
  end

  // values are distinct, so at most one cell can match
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one cell matched");

  // occupied cells stay packed at the low end
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in cell row");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(held_count))
    else $error("count does not match occupied cells");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) && !apply |=> (state == ST_APPLY) && $stable(valid_vec))
    else $error("cells changed while request was stalled");

endmodule

FILE: rtl/core/isms_cell.sv
module isms_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  isms_pkg::cell_ctl_t          ctl,
  input  logic [isms_pkg::VAL_W-1:0]   key,
  input  logic                         left_valid,
  input  logic                         left_hit,
  input  logic [isms_pkg::VAL_W-1:0]   right_value,
  input  logic                         right_valid,
  output logic [isms_pkg::VAL_W-1:0]   value,
  output logic                         valid,
  output logic                         match,
  output logic                         hit_out
);
  import isms_pkg::*;

  // any matching cell at or to the left of this one
  assign hit_out = left_hit | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match <= valid && (value == key);
      end
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.insert && !valid && left_valid) begin
        valid <= 1'b1;
      end else if (ctl.remove && hit_out) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear) begin
      if (ctl.insert && !valid && left_valid) begin
        value <= key;
      end else if (ctl.remove && hit_out) begin
        value <= right_value;
      end
    end
  end

endmodule

FILE: test/isms_result_checker.sv
`timescale 1ns / 100ps

module isms_result_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         op,
  input  logic signed [isms_pkg::VAL_W-1:0]  value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               was_present,
  input  logic [1:0]                         status,
  input  logic [isms_pkg::CNT_OUT_W-1:0]     member_count,
  output int                                 fail_count,
  output int                                 outstanding
);
  import isms_pkg::*;

  typedef struct packed {
    logic                 was_present;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] member_count;
  } set_result_t;

  // shadow copy of the set, packed in insertion order
  logic [VAL_W-1:0] shadow_cells [CAPACITY];
  int               shadow_count;
  set_result_t      expected_results [$];
  int               errors;

  initial begin
    shadow_count = 0;
    errors       = 0;
    fail_count   = 0;
    outstanding  = 0;
  end

  function automatic set_result_t apply_set_op(logic [1:0] req_op, logic [VAL_W-1:0] req_value);
    int          hit;
    set_result_t res;
    hit = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_cells[i] == req_value) hit = i;
    end
    res.was_present = (hit >= 0);
    res.status      = STAT_DONE;
    case (req_op)
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_DUPLICATE;
        end else if (shadow_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          shadow_cells[shadow_count] = req_value;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          // close the gap so order is kept
          for (int i = hit; i < shadow_count - 1; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_count--;
        end
      end
      OP_CLEAR: begin
        shadow_count    = 0;
        res.was_present = 1'b0;
      end
      default: ;
    endcase
    res.member_count = shadow_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic void flag_error(string field, int want, int got);
    errors++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin : watch
    set_result_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), apply_set_op(op, value));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $error("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (was_present !== want.was_present)
            flag_error("was_present", want.was_present, was_present);
          if (status !== want.status)
            flag_error("status", want.status, status);
          if (member_count !== want.member_count)
            flag_error("member_count", want.member_count, member_count);
        end
      end
      outstanding <= expected_results.size();
      fail_count  <= errors;
    end
  end

endmodule

FILE: test/integer_set_membership_table_tb.sv
`timescale 1ns / 100ps

module integer_set_membership_table_tb;
  import isms_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              op;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_ready;
  logic                    was_present;
  logic [1:0]              status;
  logic [CNT_OUT_W-1:0]    member_count;
  int                      fail_count;
  int                      outstanding;

  int                      idle_pct;
  int                      stall_pct;
  int                      requests_sent;
  int                      cycles;
  // what the stimulus believes the set holds, used to aim at hits
  logic [VAL_W-1:0]        live_values [$];

  integer_set_membership_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .was_present  (was_present),
    .status       (status),
    .member_count (member_count)
  );

  isms_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .was_present  (was_present),
    .status       (status),
    .member_count (member_count),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic int find_live(logic [VAL_W-1:0] v);
    int idx;
    idx = -1;
    for (int i = 0; i < live_values.size(); i++) begin
      if (idx < 0 && live_values[i] == v) idx = i;
    end
    return idx;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(int hit_pct);
    if (live_values.size() > 0 && $urandom_range(0, 99) < hit_pct)
      return live_values[$urandom_range(0, live_values.size() - 1)];
    else if ($urandom_range(0, 99) < 15)
      return $urandom_range(0, 15);
    else
      return $urandom;
  endfunction

  task automatic issue(input logic [1:0] req_op, input logic [VAL_W-1:0] req_value);
    int idx;
    idx = find_live(req_value);
    case (req_op)
      OP_INSERT: if (idx < 0 && live_values.size() < CAPACITY)
                   live_values.insert(live_values.size(), req_value);
      OP_REMOVE: if (idx >= 0) live_values.delete(idx);
      OP_CLEAR:  live_values.delete();
      default:   ;
    endcase
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= req_op;
    value    <= req_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      issue(OP_INSERT, pick_value(30));
    else if (pick < 65) issue(OP_REMOVE, pick_value(70));
    else if (pick < 96) issue(OP_QUERY, pick_value(50));
    else                issue(OP_CLEAR, $urandom);
  endtask

  // fill the table, then poke at it while full
  task automatic fill_table();
    while (live_values.size() < CAPACITY) issue(OP_INSERT, $urandom);
    repeat (3) issue(OP_INSERT, $urandom);
    issue(OP_INSERT, live_values[$urandom_range(0, CAPACITY - 1)]);
    issue(OP_QUERY, live_values[$urandom_range(0, CAPACITY - 1)]);
    issue(OP_REMOVE, live_values[$urandom_range(1, CAPACITY - 2)]);
    issue(OP_INSERT, $urandom);
    issue(OP_INSERT, $urandom);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_INSERT;
    value         = '0;
    out_ready     = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    requests_sent = 0;
    cycles        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, every op, duplicate, absent remove, shift, clear
    issue(OP_INSERT, 32'h8000_0000);
    issue(OP_INSERT, 32'h7fff_ffff);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_INSERT, 32'hffff_ffff);
    issue(OP_INSERT, 32'h5555_5555);
    issue(OP_INSERT, 32'haaaa_aaaa);
    issue(OP_INSERT, 32'h7fff_ffff);
    issue(OP_QUERY,  32'h8000_0000);
    issue(OP_QUERY,  32'h0000_0001);
    issue(OP_REMOVE, 32'h0000_0000);
    issue(OP_QUERY,  32'hffff_ffff);
    issue(OP_REMOVE, 32'h0000_0000);
    issue(OP_REMOVE, 32'h8000_0000);
    issue(OP_REMOVE, 32'haaaa_aaaa);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_QUERY,  32'h0000_0000);
    issue(OP_CLEAR,  32'h1234_5678);
    issue(OP_QUERY,  32'h7fff_ffff);
    issue(OP_REMOVE, 32'h7fff_ffff);
    issue(OP_INSERT, 32'h8000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      if (phase == 1 || phase == 3) fill_table();
      while (requests_sent < (phase + 1) * 100 + 20) random_request();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
